/* hdl/gmds_pkg.sv */
// ----------------------------------------------------------------------------
// gmds_pkg
// Types and constants shared by the grid maze solver modules.
// ----------------------------------------------------------------------------
package gmds_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int AW       = $clog2(CELLS);
    localparam int DW       = AW + 1;
    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);

    localparam logic [1:0] KIND_WALL  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_GCLR, S_IDLE, S_DECODE, S_WRITE, S_VCLR, S_INIT,
        S_CHECK, S_EVAL, S_POPLD, S_READ, S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic grid_clr;
        logic vis_clr;
        logic write_cell;
        logic init_solve;
        logic probe;
        logic push;
        logic pop;
        logic pop_load;
        logic set_found;
        logic read_issue;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic at_end;
        logic dir_done;
        logic depth_one;
        t_op  op;
    } t_sts;

endpackage

/* hdl/gmds_ctrl.sv */
// ----------------------------------------------------------------------------
// gmds_ctrl
// Sequencer for clearing passes, cell writes, the search loop and path reads.
// ----------------------------------------------------------------------------
module gmds_ctrl import gmds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_GCLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_GCLR: begin
                o_cmd.grid_clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_WRITE: n_state = S_WRITE;
                    OP_SOLVE: n_state = S_VCLR;
                    OP_READ:  n_state = S_READ;
                    default:  n_state = S_RESP;
                endcase
            end
            S_WRITE: begin
                o_cmd.write_cell = 1'b1;
                n_state          = S_RESP;
            end
            S_VCLR: begin
                o_cmd.vis_clr = 1'b1;
                if (i_sts.clr_last) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_solve = 1'b1;
                n_state          = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.at_end) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_RESP;
                end else if (i_sts.dir_done) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_sts.depth_one ? S_RESP : S_POPLD;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.push = 1'b1;
                n_state    = S_CHECK;
            end
            S_POPLD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_CHECK;
            end
            S_READ: begin
                o_cmd.read_issue = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* hdl/gmds_dp.sv */
// ----------------------------------------------------------------------------
// gmds_dp
// Maze, visited and path stack memories, position and size registers.
// ----------------------------------------------------------------------------
module gmds_dp import gmds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic [1:0]    i_opcode,
    input  logic [RW-1:0] i_cell_row,
    input  logic [CW-1:0] i_cell_col,
    input  logic [1:0]    i_cell_kind,
    input  logic [AW-1:0] i_path_index,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [5:0]    i_cfg_data,
    output logic          o_done,
    output logic          o_found,
    output logic [DW-1:0] o_path_length,
    output logic [RW-1:0] o_step_row,
    output logic [CW-1:0] o_step_col,
    output logic          o_index_ok
);

    logic [1:0]       mem_grid [CELLS];
    logic             mem_vis  [CELLS];
    logic [RW+CW+2:0] mem_stk  [CELLS];

    logic [5:0]    r_rows, r_cols;
    logic [RW-1:0] r_start_row, r_end_row, r_top_row, r_nb_row, r_row, r_step_row;
    logic [CW-1:0] r_start_col, r_end_col, r_top_col, r_nb_col, r_col, r_step_col;
    logic [2:0]    r_top_dir;
    logic          r_found, r_nb_ok, r_vis_rd, r_done, r_ok;
    logic [DW-1:0] r_depth;
    logic [AW-1:0] r_clr, r_idx;
    t_op           r_op;
    logic [1:0]    r_kind, r_grid_rd;
    logic [RW+CW+2:0] r_stk_rd;

    logic [5:0]    nr, nc;
    logic          mv, nb_ok, can_push, in_range;
    logic          grid_we, vis_we, vis_wd, stk_we;
    logic [AW-1:0] grid_wa, vis_wa, stk_wa, stk_ra, nb_addr;
    logic [1:0]    grid_wd;
    logic [DW-1:0] depth_m1, depth_m2;

    always_comb begin
        nr = {1'b0, r_top_row};
        nc = {1'b0, r_top_col};
        mv = 1'b1;
        unique case (r_top_dir[1:0])
            2'd0: begin nr = nr - 6'd1; mv = (r_top_row != '0); end
            2'd1: nc = nc + 6'd1;
            2'd2: nr = nr + 6'd1;
            default: begin nc = nc - 6'd1; mv = (r_top_col != '0); end
        endcase
    end

    assign nb_ok    = mv && !nr[5] && !nc[5] && (nr < r_rows) && (nc < r_cols);
    assign nb_addr  = {nr[RW-1:0], nc[CW-1:0]};
    assign can_push = r_nb_ok && !r_vis_rd && (r_depth < DW'(CELLS))
                      && (r_grid_rd == KIND_OPEN || r_grid_rd == KIND_END);
    assign in_range = ({1'b0, r_row} < r_rows) && ({1'b0, r_col} < r_cols);
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    assign grid_we = i_cmd.grid_clr || (i_cmd.write_cell && in_range);
    assign grid_wa = i_cmd.grid_clr ? r_clr : {r_row, r_col};
    assign grid_wd = i_cmd.grid_clr ? KIND_OPEN : r_kind;

    assign vis_we = i_cmd.vis_clr || i_cmd.init_solve || (i_cmd.push && can_push);
    assign vis_wd = !i_cmd.vis_clr;
    always_comb begin
        priority if (i_cmd.vis_clr)   vis_wa = r_clr;
        else if (i_cmd.init_solve)    vis_wa = {r_start_row, r_start_col};
        else                          vis_wa = {r_nb_row, r_nb_col};
    end

    assign stk_we = (i_cmd.push && can_push) || i_cmd.set_found;
    assign stk_wa = depth_m1[AW-1:0];
    assign stk_ra = i_cmd.read_issue ? r_idx : depth_m2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (grid_we) mem_grid[grid_wa] <= grid_wd;
        r_grid_rd <= mem_grid[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) mem_vis[vis_wa] <= vis_wd;
        r_vis_rd <= mem_vis[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) mem_stk[stk_wa] <= {r_top_dir, r_top_row, r_top_col};
        r_stk_rd <= mem_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= 6'(MAX_ROWS);
            r_cols      <= 6'(MAX_COLS);
            r_start_row <= '0;
            r_start_col <= '0;
            r_end_row   <= '0;
            r_end_col   <= '0;
            r_found     <= 1'b0;
            r_depth     <= '0;
            r_clr       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.respond;
            if (i_cfg_we && i_cfg_index == CFG_ROWS) r_rows <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_COLS) r_cols <= i_cfg_data;
            if (i_cmd.capture) r_clr <= '0;
            else if (i_cmd.grid_clr || i_cmd.vis_clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.write_cell && in_range && r_kind == KIND_START) begin
                r_start_row <= r_row;
                r_start_col <= r_col;
            end
            if (i_cmd.write_cell && in_range && r_kind == KIND_END) begin
                r_end_row <= r_row;
                r_end_col <= r_col;
            end
            if (i_cmd.init_solve) begin
                r_found <= 1'b0;
                r_depth <= DW'(1);
            end
            if (i_cmd.push && can_push) r_depth <= r_depth + DW'(1);
            if (i_cmd.pop) r_depth <= depth_m1;
            if (i_cmd.set_found) r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_opcode);
            r_row  <= i_cell_row;
            r_col  <= i_cell_col;
            r_kind <= i_cell_kind;
            r_idx  <= i_path_index;
        end
        if (i_cmd.init_solve) begin
            r_top_row <= r_start_row;
            r_top_col <= r_start_col;
            r_top_dir <= '0;
        end
        if (i_cmd.probe) begin
            r_nb_row  <= nr[RW-1:0];
            r_nb_col  <= nc[CW-1:0];
            r_nb_ok   <= nb_ok;
            r_top_dir <= r_top_dir + 3'd1;
        end
        if (i_cmd.push && can_push) begin
            r_top_row <= r_nb_row;
            r_top_col <= r_nb_col;
            r_top_dir <= '0;
        end
        if (i_cmd.pop_load) begin
            {r_top_dir, r_top_row, r_top_col} <= r_stk_rd;
        end
        if (i_cmd.respond) begin
            if (r_op == OP_READ && {1'b0, r_idx} < r_depth) begin
                r_ok       <= 1'b1;
                r_step_row <= r_stk_rd[RW+CW-1:CW];
                r_step_col <= r_stk_rd[CW-1:0];
            end else begin
                r_ok       <= 1'b0;
                r_step_row <= '0;
                r_step_col <= '0;
            end
        end
    end

    assign o_sts.clr_last  = (r_clr == '1);
    assign o_sts.at_end    = (r_top_row == r_end_row) && (r_top_col == r_end_col);
    assign o_sts.dir_done  = r_top_dir[2];
    assign o_sts.depth_one = (r_depth == DW'(1));
    assign o_sts.op        = r_op;

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_path_length = r_depth;
    assign o_step_row    = r_step_row;
    assign o_step_col    = r_step_col;
    assign o_index_ok    = r_ok;

endmodule

/* hdl/grid_maze_dfs_backtrack_solver.sv */
// ----------------------------------------------------------------------------
// grid_maze_dfs_backtrack_solver
// Grid maze solver, depth-first search with backtracking, maze up to 32x32.
//
// channel  | handshake              | word
// ---------+------------------------+---------------------------------------
// command  | i_start / o_busy       | opcode, cell_row/col/kind, path_index
// result   | o_done (1-cycle pulse) | found, path_length, step_row/col, ok
// config   | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
//
// Write cell and path read go through decode, their own state and response;
// opcode 3 goes from decode to response. A solve clears all 1024 visited
// bits, then probes and evaluates each neighbor and pops and reloads on each
// backtrack. After reset a pass sets every maze cell open; busy stays high.
// Results cannot be stalled; one word per accepted command.
// ----------------------------------------------------------------------------
module grid_maze_dfs_backtrack_solver import gmds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  logic [1:0]    i_opcode,
    input  logic [4:0]    i_cell_row,
    input  logic [4:0]    i_cell_col,
    input  logic [1:0]    i_cell_kind,
    input  logic [9:0]    i_path_index,
    output logic          o_done,
    output logic          o_found,
    output logic [10:0]   o_path_length,
    output logic [4:0]    o_step_row,
    output logic [4:0]    o_step_col,
    output logic          o_index_ok,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [5:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    gmds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    gmds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_cell_kind   (i_cell_kind),
        .i_path_index  (i_path_index),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_path_length (o_path_length),
        .o_step_row    (o_step_row),
        .o_step_col    (o_step_col),
        .o_index_ok    (o_index_ok)
    );

endmodule

/* hdl/gmds_chk.sv */
// ----------------------------------------------------------------------------
// gmds_chk
// Port-level checks for the grid maze solver, bound to the top level.
// ----------------------------------------------------------------------------
module gmds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_found,
    input logic [10:0] o_path_length,
    input logic        o_index_ok
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy low after accept");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");

    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result word without a command");

    a_found_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_found == (o_path_length != 11'd0)))
        else $error("found and path length disagree");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_index_ok) |-> (o_path_length != 11'd0))
        else $error("index_ok without a path");

endmodule

bind grid_maze_dfs_backtrack_solver gmds_chk u_gmds_chk (.*);
